// ----- rtl/core/pcxrle_pkg.sv -----
// shared types, codes and constants for the pcx run-length scanline decoder
package pcxrle_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // item function codes
    localparam logic [1:0] FN_DATA = 2'd0;
    localparam logic [1:0] FN_END  = 2'd1;
    localparam logic [1:0] FN_NEW  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES   = 2'd2;

    localparam logic [7:0] RUN_MARK     = 8'hC0;
    localparam logic [7:0] RUN_LEN_MASK = 8'h3F;

    localparam logic [10:0] WIDTH_RESET  = 11'd320;
    localparam logic [10:0] HEIGHT_RESET = 11'd200;
    localparam logic [15:0] LBYTES_RESET = 16'd320;

    localparam logic [10:0] MAX_WIDTH_V  = 11'(MAX_WIDTH);
    localparam logic [10:0] MAX_HEIGHT_V = 11'(MAX_HEIGHT);

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  pixel_value;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [19:0] pixel_address;
        logic        last_of_run;
        logic        frame_done;
        logic        read_error;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PLAN,
        ST_RUN,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_STATUS,
        EM_FIN,
        EM_PIXEL
    } emit_t;

    typedef struct packed {
        logic  load_item;
        logic  set_done;
        logic  next_line;
        logic  start_hdr;
        logic  clr_await;
        logic  load_pending;
        logic  load_one;
        logic  plan;
        logic  finalize;
        logic  new_frame;
        logic  col_step;
        emit_t emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       done_now;
        logic       col_ge_lb;
        logic       awaiting;
        logic       run_hdr;
        logic       any_pixel;
        logic       last_pixel;
        logic       out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/pcx_rle_scanline_decoder_core.sv -----
// top level of the pcx 8-bit run-length scanline decoder
// an accepted item is registered, then checked: a run header, control item or data for a
// finished frame answers with one status word; other data is planned, then emits its run
// pixels, one word per cycle while the receiver takes them, or a closing status word; one
// item at a time; a line shortened under the decoder is closed before its data goes on
// reset: asynchronous, active low; config returns to 320 x 200, 320 bytes per line
module pcx_rle_scanline_decoder_core
    import pcxrle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // encoded stream words
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    // decoded result words
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    // register writes, always accepted
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: accept, check line and frame state, plan the run, emit pixels
    pcxrle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // state registers, run bounds and the output word register
    pcxrle_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ----- rtl/core/pcxrle_ctrl.sv -----
// controller state machine for the pcx run-length decoder
module pcxrle_ctrl
    import pcxrle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = EM_NONE;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.out_free)
                begin
                    if (stat.func == FN_DATA)
                    begin
                        if (stat.done_now)
                        begin
                            cmd.set_done = 1'b1;
                            cmd.emit     = EM_STATUS;
                            state_next   = ST_IDLE;
                        end
                        else if (stat.col_ge_lb)
                        begin
                            // line shortened under us: close it and look again
                            cmd.next_line = 1'b1;
                        end
                        else if (stat.awaiting)
                        begin
                            cmd.clr_await    = 1'b1;
                            cmd.load_pending = 1'b1;
                            state_next       = ST_PLAN;
                        end
                        else if (stat.run_hdr)
                        begin
                            cmd.start_hdr = 1'b1;
                            cmd.emit      = EM_STATUS;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            cmd.load_one = 1'b1;
                            state_next   = ST_PLAN;
                        end
                    end
                    else if (stat.func == FN_END)
                    begin
                        cmd.set_done = 1'b1;
                        cmd.emit     = EM_STATUS;
                        state_next   = ST_IDLE;
                    end
                    else if (stat.func == FN_NEW)
                    begin
                        cmd.new_frame = 1'b1;
                        cmd.emit      = EM_STATUS;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit   = EM_STATUS;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = stat.any_pixel ? ST_RUN : ST_FIN;
            end
            ST_RUN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = EM_PIXEL;
                    if (stat.last_pixel)
                    begin
                        cmd.finalize = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.col_step = 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finalize = 1'b1;
                    cmd.emit     = EM_FIN;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/pcxrle_dp.sv -----
// datapath: config registers, decode state, run planning and output register
module pcxrle_dp
    import pcxrle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  item_t                 item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output result_t               result,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat
);

    logic [10:0] img_w_reg, img_h_reg;
    logic [15:0] lbytes_reg;

    logic [10:0] row_reg;
    logic [15:0] col_reg;
    logic        await_reg;
    logic [5:0]  pend_reg;
    logic [19:0] base_reg;
    logic        done_reg;

    logic [1:0]  func_reg;
    logic [7:0]  byte_reg;
    logic [5:0]  count_reg;
    logic [15:0] cut_end_reg;
    logic        reach_reg;
    logic        run_done_reg;

    logic        out_valid_reg;
    result_t     out_reg;

    logic [10:0] eff_w, eff_h;
    logic        done_now, new_done, stat_done, stat_err;
    logic [16:0] end_sum, col_inc;
    logic        reach, done_after;
    logic [15:0] cut_end;
    logic [11:0] row_inc;

    assign cfg_ready = 1'b1;

    assign eff_w = (img_w_reg > MAX_WIDTH_V) ? MAX_WIDTH_V : img_w_reg;
    assign eff_h = (img_h_reg > MAX_HEIGHT_V) ? MAX_HEIGHT_V : img_h_reg;

    assign done_now = done_reg || (row_reg >= eff_h) || (lbytes_reg == 16'd0);
    assign new_done = (eff_h == 11'd0) || (lbytes_reg == 16'd0);
    assign row_inc  = {1'b0, row_reg} + 12'd1;

    // run planning
    assign end_sum    = {1'b0, col_reg} + {11'd0, count_reg};
    assign reach      = end_sum >= {1'b0, lbytes_reg};
    assign cut_end    = reach ? lbytes_reg : end_sum[15:0];
    assign done_after = done_reg || (reach && (row_inc >= {1'b0, eff_h}));
    assign col_inc    = {1'b0, col_reg} + 17'd1;

    always_comb
    begin
        case (func_reg)
            FN_DATA: stat_done = done_now;
            FN_END:  stat_done = done_now;
            FN_NEW:  stat_done = new_done;
            default: stat_done = done_reg;
        endcase
        stat_err = (func_reg == FN_END) && !done_now;
    end

    assign stat.func       = func_reg;
    assign stat.done_now   = done_now;
    assign stat.col_ge_lb  = col_reg >= lbytes_reg;
    assign stat.awaiting   = await_reg;
    assign stat.run_hdr    = (byte_reg & RUN_MARK) == RUN_MARK;
    assign stat.any_pixel  = (count_reg != 6'd0) && (col_reg < {5'd0, eff_w});
    assign stat.last_pixel = (col_inc >= {1'b0, cut_end_reg}) || (col_inc >= {6'd0, eff_w});
    assign stat.out_free   = !out_valid_reg || result_ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg  <= WIDTH_RESET;
            img_h_reg  <= HEIGHT_RESET;
            lbytes_reg <= LBYTES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  img_w_reg  <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT: img_h_reg  <= cfg_data[10:0];
                CFG_LINE_BYTES:   lbytes_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            await_reg <= 1'b0;
            pend_reg  <= '0;
            base_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.set_done)
            begin
                done_reg <= done_now;
            end
            if (cmd.next_line)
            begin
                col_reg  <= '0;
                row_reg  <= row_inc[10:0];
                base_reg <= base_reg + {9'd0, eff_w};
            end
            if (cmd.start_hdr)
            begin
                pend_reg  <= 6'(byte_reg & RUN_LEN_MASK);
                await_reg <= 1'b1;
            end
            if (cmd.clr_await)
            begin
                await_reg <= 1'b0;
            end
            if (cmd.col_step)
            begin
                col_reg <= col_inc[15:0];
            end
            if (cmd.finalize)
            begin
                if (reach_reg)
                begin
                    col_reg  <= '0;
                    row_reg  <= row_inc[10:0];
                    base_reg <= base_reg + {9'd0, eff_w};
                    done_reg <= run_done_reg;
                end
                else
                begin
                    col_reg <= cut_end_reg;
                end
            end
            if (cmd.new_frame)
            begin
                row_reg   <= '0;
                col_reg   <= '0;
                await_reg <= 1'b0;
                pend_reg  <= '0;
                base_reg  <= '0;
                done_reg  <= new_done;
            end
        end
    end

    // item and run registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg <= FN_DATA;
        end
        else if (cmd.load_item)
        begin
            func_reg <= item.func;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            byte_reg <= item.data_byte;
        end
        if (cmd.load_pending)
        begin
            count_reg <= pend_reg;
        end
        if (cmd.load_one)
        begin
            count_reg <= 6'd1;
        end
        if (cmd.plan)
        begin
            cut_end_reg  <= cut_end;
            reach_reg    <= reach;
            run_done_reg <= done_after;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit != EM_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.emit)
            EM_STATUS:
            begin
                out_reg.pixel_valid   <= 1'b0;
                out_reg.pixel_value   <= '0;
                out_reg.pixel_x       <= '0;
                out_reg.pixel_y       <= '0;
                out_reg.pixel_address <= '0;
                out_reg.last_of_run   <= 1'b1;
                out_reg.frame_done    <= stat_done;
                out_reg.read_error    <= stat_err;
            end
            EM_FIN:
            begin
                out_reg.pixel_valid   <= 1'b0;
                out_reg.pixel_value   <= '0;
                out_reg.pixel_x       <= '0;
                out_reg.pixel_y       <= '0;
                out_reg.pixel_address <= '0;
                out_reg.last_of_run   <= 1'b1;
                out_reg.frame_done    <= reach_reg ? run_done_reg : done_reg;
                out_reg.read_error    <= 1'b0;
            end
            EM_PIXEL:
            begin
                out_reg.pixel_valid   <= 1'b1;
                out_reg.pixel_value   <= byte_reg;
                out_reg.pixel_x       <= col_reg[9:0];
                out_reg.pixel_y       <= row_reg[9:0];
                out_reg.pixel_address <= base_reg + {4'd0, col_reg};
                out_reg.last_of_run   <= stat.last_pixel;
                out_reg.frame_done    <= reach_reg ? run_done_reg : done_reg;
                out_reg.read_error    <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

// ----- rtl/core/pcxrle_checker.sv -----
// port-level assertions for the decoder, bound to the top level
module pcxrle_checker
    import pcxrle_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while previous one still in work");

    // a run still emitting blocks new items
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_of_run |-> !item_ready)
        else $error("item ready in the middle of a run");

    // a read error is a status word of an unfinished frame
    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.read_error |-> !result.frame_done && !result.pixel_valid
            && result.last_of_run)
        else $error("bad read error word");

endmodule

bind pcx_rle_scanline_decoder_core pcxrle_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ----- tb/sv/tb_pcx_rle_scanline_decoder_core.sv -----
// self-checking testbench for the pcx run-length scanline decoder core
`timescale 1ns / 100ps

module tb_pcx_rle_scanline_decoder_core;
    import pcxrle_pkg::*;

    // codes the package leaves unnamed: spare function and spare register slot
    localparam logic [1:0]           FN_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // idle cycles allowed after the last owed word before the block counts as quiet
    localparam int SETTLE_CYCLES = 8;
    // receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES   = 400;
    localparam int SCRIPT_ROWS   = 37;

    // one row of the directed script: either a register write or a stream word,
    // with a hand-written result where it is obvious
    typedef struct packed {
        logic                  is_cfg;
        item_t                 w;
        logic [CFG_IDX_W-1:0]  ridx;
        logic [15:0]           rdata;
        logic                  typed;
        result_t               want;
    } row_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // decoded words owed by the block, oldest first
    result_t decoded_q [$];
    // words one input produces, built by the decoder model
    result_t step_words [$];

    int  mismatches = 0;
    int  burst_left = 0;
    bit  stall_ask  = 1'b0;

    // decoder model: register copies and scan position
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [15:0] lbytes_reg;
    int unsigned row_n;
    int unsigned col_n;
    int unsigned run_len;
    int unsigned base_addr;
    bit          await_val;
    bit          done_flag;

    pcx_rle_scanline_decoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // decoder model
    // ---------------------------------------------------------------

    // stored width and height saturate at the build maximum
    function automatic int unsigned stored_width();
        if (width_reg > MAX_WIDTH_V)
            return 32'(MAX_WIDTH);
        return 32'(width_reg);
    endfunction

    function automatic int unsigned stored_height();
        if (height_reg > MAX_HEIGHT_V)
            return 32'(MAX_HEIGHT);
        return 32'(height_reg);
    endfunction

    // done is sticky until a new frame starts
    task automatic refresh_done();
        if (row_n >= stored_height() || lbytes_reg == 16'd0)
            done_flag = 1'b1;
    endtask

    task automatic close_line();
        col_n     = 0;
        row_n     = (row_n + 1) & 32'h7FF;
        base_addr = (base_addr + stored_width()) & 32'hFFFFF;
        refresh_done();
    endtask

    // paint count copies of value from the current column; a run that hits
    // the line end is cut there and the remainder is lost
    task automatic paint_run(int unsigned count, logic [7:0] value);
        result_t     px;
        int unsigned k;
        bit          line_end;
        line_end = 1'b0;
        for (k = 0; k < count && !line_end; k++)
        begin
            if (col_n < stored_width())
            begin
                px               = '0;
                px.pixel_valid   = 1'b1;
                px.pixel_value   = value;
                px.pixel_x       = col_n[9:0];
                px.pixel_y       = row_n[9:0];
                px.pixel_address = 20'((base_addr + col_n) & 32'hFFFFF);
                step_words.push_back(px);
            end
            col_n = (col_n + 1) & 32'hFFFF;
            if (col_n >= lbytes_reg)
            begin
                close_line();
                line_end = 1'b1;
            end
        end
    endtask

    // advance the model by one accepted stream word; fills step_words
    task automatic decode_word(item_t w);
        bit      short_data;
        int      i;
        result_t r;
        short_data = 1'b0;
        step_words.delete();
        case (w.func)
            FN_DATA:
            begin
                refresh_done();
                // a register write may have shortened the line under us
                if (!done_flag && col_n >= lbytes_reg)
                    close_line();
                refresh_done();
                if (!done_flag)
                begin
                    if (await_val)
                    begin
                        await_val = 1'b0;
                        paint_run(run_len, w.data_byte);
                    end
                    else if ((w.data_byte & RUN_MARK) == RUN_MARK)
                    begin
                        run_len   = int'(w.data_byte & RUN_LEN_MASK);
                        await_val = 1'b1;
                    end
                    else
                        paint_run(1, w.data_byte);
                end
            end
            FN_END:
            begin
                refresh_done();
                short_data = !done_flag;
            end
            FN_NEW:
            begin
                row_n     = 0;
                col_n     = 0;
                await_val = 1'b0;
                run_len   = 0;
                base_addr = 0;
                done_flag = 1'b0;
                refresh_done();
            end
            default: ;
        endcase
        // anything that paints nothing still answers with one status word
        if (step_words.size() == 0)
            step_words.push_back(result_t'('0));
        for (i = 0; i < step_words.size(); i++)
        begin
            r             = step_words[i];
            r.last_of_run = (i == step_words.size() - 1);
            r.frame_done  = done_flag;
            r.read_error  = short_data;
            step_words[i] = r;
        end
    endtask

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic flag_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic inspect_word(result_t got);
        result_t want;
        if (decoded_q.size() == 0)
        begin
            flag_mismatch($sformatf("word %h arrived with nothing owed", got));
            return;
        end
        want = decoded_q.pop_front();
        if (got.pixel_valid !== want.pixel_valid)
            flag_mismatch($sformatf("pixel_valid %b, want %b", got.pixel_valid, want.pixel_valid));
        if (got.pixel_value !== want.pixel_value)
            flag_mismatch($sformatf("pixel_value %h, want %h", got.pixel_value, want.pixel_value));
        if (got.pixel_x !== want.pixel_x)
            flag_mismatch($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
        if (got.pixel_y !== want.pixel_y)
            flag_mismatch($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
        if (got.pixel_address !== want.pixel_address)
            flag_mismatch($sformatf("pixel_address %h, want %h",
                                    got.pixel_address, want.pixel_address));
        if (got.last_of_run !== want.last_of_run)
            flag_mismatch($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
        if (got.frame_done !== want.frame_done)
            flag_mismatch($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
        if (got.read_error !== want.read_error)
            flag_mismatch($sformatf("read_error %b, want %b", got.read_error, want.read_error));
    endtask

    // outputs are sampled at the edge, before the block updates them
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            inspect_word(result);
    end

    // ---------------------------------------------------------------
    // receiver: changing stall pattern plus an occasional long hold-off
    // ---------------------------------------------------------------
    initial
    begin : sink_side
        int          hold_left;
        int          mode_left;
        int          pace;
        int unsigned tick;
        bit          take;
        hold_left = 0;
        mode_left = 0;
        pace      = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (stall_ask && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                stall_ask = 1'b0;
            end
            if (mode_left == 0)
            begin
                pace      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
            begin
                case (pace)
                    0:       take = 1'b1;
                    1:       take = $urandom_range(0, 1) != 0;
                    2:       take = $urandom_range(0, 3) != 0;
                    default: take = (tick % 3) != 0;
                endcase
            end
            result_ready <= take;
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // wait until every owed word is out and the block has had time to go idle
    task automatic settle_out();
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // offer one stream word, hold it until taken, then book what it owes;
    // bursts end in a random gap
    task automatic send_word(item_t w, bit typed, result_t want);
        item       <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        decode_word(w);
        if (typed)
            decoded_q.push_back(want);
        else
            foreach (step_words[i])
                decoded_q.push_back(step_words[i]);
        burst_left--;
        if (burst_left <= 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // register writes only go in while the block is quiet
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        item_valid <= 1'b0;
        settle_out();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  width_reg  = val[10:0];
            CFG_IMAGE_HEIGHT: height_reg = val[10:0];
            CFG_LINE_BYTES:   lbytes_reg = val;
            default: ;
        endcase
    endtask

    // mostly well-formed streams: literals and header/value pairs, a new
    // frame soon after one completes, some end markers, spares and noise
    task automatic random_stream(int n);
        int    live;
        int    pick;
        bit    ignored;
        item_t w;
        live = 0;
        while (live < n)
        begin
            pick        = $urandom_range(0, 99);
            w.func      = FN_DATA;
            w.data_byte = 8'($urandom_range(0, 255));
            if (done_flag && pick < 70)
                w.func = FN_NEW;
            else if (await_val && pick < 90)
                ;   // run value, any byte
            else if (pick < 55)
                w.data_byte = 8'($urandom_range(0, 8'hBF));
            else if (pick < 82)
                w.data_byte = RUN_MARK | 8'($urandom_range(0, 63));
            else if (pick < 86)
                w.func = FN_NEW;
            else if (pick < 90)
                w.func = FN_END;
            else if (pick < 93)
                w.func = FN_SPARE;
            else if (pick < 95)
            begin
                // let everything drain before the next word
                item_valid <= 1'b0;
                settle_out();
            end
            ignored = (w.func == FN_DATA) && done_flag;
            send_word(w, 1'b0, '0);
            if (!ignored)
                live++;
        end
    endtask

    // one setting of all three registers, an optional new frame, then a random stream
    task automatic run_phase(logic [15:0] w, logic [15:0] h, logic [15:0] lb,
                             bit fresh, int n, bit squeeze);
        item_t start;
        start      = '0;
        start.func = FN_NEW;
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_LINE_BYTES, lb);
        if (fresh)
            send_word(start, 1'b0, '0);
        // back the block up: receiver stops while words keep coming
        if (squeeze)
            stall_ask = 1'b1;
        random_stream(n);
    endtask

    function automatic result_t status_word(logic done, logic err);
        result_t r;
        r             = '0;
        r.last_of_run = 1'b1;
        r.frame_done  = done;
        r.read_error  = err;
        return r;
    endfunction

    function automatic row_t word_row(logic [1:0] f, logic [7:0] b);
        row_t r;
        r             = '0;
        r.w.func      = f;
        r.w.data_byte = b;
        return r;
    endfunction

    function automatic row_t sure_row(logic [1:0] f, logic [7:0] b, result_t want);
        row_t r;
        r       = word_row(f, b);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.ridx   = idx;
        r.rdata  = val;
        return r;
    endfunction

    initial
    begin : stimulus
        row_t    script [SCRIPT_ROWS];
        result_t origin_px;
        int      k;

        // model starts from the reset settings
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        lbytes_reg = LBYTES_RESET;
        row_n      = 0;
        col_n      = 0;
        run_len    = 0;
        base_addr  = 0;
        await_val  = 1'b0;
        done_flag  = 1'b0;
        burst_left = 4;

        origin_px = '{1'b1, 8'h00, 10'd0, 10'd0, 20'd0, 1'b1, 1'b0, 1'b0};

        script = '{
            // reset settings: early end, spare function, first literal
            sure_row(FN_END,   8'h00, status_word(1'b0, 1'b1)),
            sure_row(FN_SPARE, 8'hFF, status_word(1'b0, 1'b0)),
            sure_row(FN_DATA,  8'h00, origin_px),
            word_row(FN_DATA,  8'hBF),
            // 4 stored columns, 6 bytes per line, 3 rows
            reg_row(CFG_IMAGE_WIDTH,  16'd4),
            reg_row(CFG_IMAGE_HEIGHT, 16'd3),
            reg_row(CFG_LINE_BYTES,   16'd6),
            sure_row(FN_NEW,   8'h00, status_word(1'b0, 1'b0)),
            // zero-count run swallows its value
            word_row(FN_DATA,  8'hC0),
            word_row(FN_DATA,  8'h55),
            // run of 63 cut at the line end, padding dropped
            word_row(FN_DATA,  8'hFF),
            word_row(FN_DATA,  8'hAA),
            // end marker while a run value is awaited
            word_row(FN_DATA,  8'hC3),
            word_row(FN_END,   8'h00),
            word_row(FN_DATA,  8'h7E),
            word_row(FN_DATA,  8'h01),
            word_row(FN_DATA,  8'h80),
            // shorten the line below the current column
            reg_row(CFG_LINE_BYTES,   16'd3),
            word_row(FN_DATA,  8'h3F),
            word_row(FN_DATA,  8'hC2),
            word_row(FN_DATA,  8'h40),
            // frame complete: data ignored, end marker is clean
            word_row(FN_DATA,  8'h12),
            sure_row(FN_END,   8'h00, status_word(1'b1, 1'b0)),
            // width zero via upper bits, height capped, widest line
            reg_row(CFG_IMAGE_WIDTH,  16'hF800),
            reg_row(CFG_IMAGE_HEIGHT, 16'hFFFF),
            reg_row(CFG_LINE_BYTES,   16'hFFFF),
            sure_row(FN_NEW,   8'h00, status_word(1'b0, 1'b0)),
            word_row(FN_DATA,  8'hFF),
            word_row(FN_DATA,  8'h01),
            reg_row(CFG_SPARE,        16'hFFFF),
            // zero line bytes: done at once
            reg_row(CFG_LINE_BYTES,   16'd0),
            sure_row(FN_NEW,   8'h00, status_word(1'b1, 1'b0)),
            word_row(FN_DATA,  8'h11),
            // zero height: done at once
            reg_row(CFG_LINE_BYTES,   16'd5),
            reg_row(CFG_IMAGE_HEIGHT, 16'd0),
            sure_row(FN_NEW,   8'h00, status_word(1'b1, 1'b0)),
            sure_row(FN_END,   8'h00, status_word(1'b1, 1'b0))
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (k = 0; k < SCRIPT_ROWS; k++)
        begin
            if (script[k].is_cfg)
                write_reg(script[k].ridx, script[k].rdata);
            else
                send_word(script[k].w, script[k].typed, script[k].want);
        end

        // fixed corners first, then random small frames
        run_phase(16'd8,    16'd4,    16'd10,    1'b1, 40, 1'b1);
        run_phase(16'd1,    16'd1,    16'd1,     1'b1, 25, 1'b0);
        run_phase(16'hFFFF, 16'd2,    16'hFFFF,  1'b1, 30, 1'b0);
        run_phase(16'd1024, 16'd1024, 16'd1024,  1'b0, 40, 1'b1);
        run_phase(16'd0,    16'd3,    16'd5,     1'b1, 20, 1'b0);
        run_phase(16'd5,    16'd0,    16'd5,     1'b1, 15, 1'b0);
        run_phase(16'd6,    16'd3,    16'd0,     1'b0, 15, 1'b0);
        repeat (3)
        begin
            k = $urandom_range(1, 40);
            run_phase(16'(k), 16'($urandom_range(1, 6)), 16'($urandom_range(1, k + 8)),
                      1'($urandom_range(0, 1)), 20, 1'($urandom_range(0, 1)));
        end

        item_valid <= 1'b0;
        settle_out();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
